// File: rtl/scaled_blit_source_address_gen_macros.svh
// ----------------------------------------------------------------------------
// Scaled blit source address generator: assertion macros
// Concurrent assertion helpers shared by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef SCALED_BLIT_SOURCE_ADDRESS_GEN_MACROS_SVH
`define SCALED_BLIT_SOURCE_ADDRESS_GEN_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBAG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbag assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SBAG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbag assertion failed");

`endif

// File: rtl/sbag_pkg.sv
// ----------------------------------------------------------------------------
// Scaled blit source address generator package
// Widths, register map codes and the count clamp shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbag_pkg;

   localparam int MAX_IMAGE_DIM = 4096;
   localparam int CNT_W         = $clog2(MAX_IMAGE_DIM);   // counter width
   localparam int COUNT_W       = 13;                      // count register width
   localparam int STRIDE_W      = 13;
   localparam int STEP_W        = 24;
   localparam int FRAC_W        = 16;
   localparam int INDEX_W       = 40;                      // 24.16 index
   localparam int PIXEL_W       = 24;
   localparam int WHOLE_W       = STEP_W + 1 - FRAC_W;     // whole rows per step
   localparam int PROD_W        = WHOLE_W + STRIDE_W;
   localparam int MIRROR_W      = 2;

   localparam int CSR_ADDR_W    = 6;
   localparam int CSR_DATA_W    = 64;

   typedef enum logic [2:0] {
      REG_ROW_STRIDE   = 3'd0,
      REG_COLUMN_STEP  = 3'd1,
      REG_ROW_STEP     = 3'd2,
      REG_START_INDEX  = 3'd3,
      REG_START_FRAC   = 3'd4,
      REG_COLUMNS      = 3'd5,
      REG_ROWS         = 3'd6,
      REG_MIRROR_MODE  = 3'd7
   } csr_index_type;

   localparam logic [STRIDE_W-1:0] ROW_STRIDE_RESET  = STRIDE_W'(1);
   localparam logic [STEP_W-1:0]   COLUMN_STEP_RESET = STEP_W'(65536);
   localparam logic [STEP_W-1:0]   ROW_STEP_RESET    = STEP_W'(65536);
   localparam logic [COUNT_W-1:0]  COUNT_RESET       = COUNT_W'(1);

   localparam int MIRROR_H_BIT = 0;
   localparam int MIRROR_V_BIT = 1;

   // Map a count register to the last counter position: zero acts as one,
   // anything above the maximum acts as the maximum.
   function automatic logic [CNT_W-1:0] count_limit(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] c;
      begin
         if (v == '0) begin
            c = COUNT_W'(1);
         end else if (v > COUNT_W'(MAX_IMAGE_DIM)) begin
            c = COUNT_W'(MAX_IMAGE_DIM);
         end else begin
            c = v;
         end
         count_limit = CNT_W'(c - COUNT_W'(1));
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/sbag_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying the rewind flag of one request transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbag_req_if;
   logic valid;
   logic ready;
   logic rewind;

   modport source (output valid, output rewind, input ready);
   modport sink   (input valid, input rewind, output ready);
endinterface

`default_nettype wire

// File: rtl/sbag_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one source pixel address transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbag_rsp_if import sbag_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_index;
   logic               row_end;
   logic               last;

   modport source (output valid, output pixel_index, output row_end, output last,
                   input ready);
   modport sink   (input valid, input pixel_index, input row_end, input last,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/scaled_blit_source_address_gen.sv
// ----------------------------------------------------------------------------
// Scaled blit source address generator
// Nearest-neighbor source pixel index walker for a scaled, mirrored blit.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan  - one transaction per destination pixel; rewind=1 restarts the
//               scan at the region start before the address is produced.
//   rsp_chan  - one transaction per request: integer source pixel index plus
//               row_end and last marks.
//   APB port  - eight registers at byte address 8*i, 64-bit data. Program
//               them only while no request is in flight; new start values
//               apply at the next rewind or after the region wraps.
// Latency: a response is valid the cycle after its request is accepted.
// Throughput: one transaction per clock while rsp_chan.ready stays high. The walk
//   state is updated in the accept cycle, so the next request sees it at once;
//   the path is one 9x13 multiply and a 40-bit add, feeding the walk state registers.
// Reset: registers take their reset values and the scan sits at the start.
// Stall: the response register holds while rsp_chan.ready is low, and
//   req_chan.ready drops until the response is taken (it stays high when the
//   response leaves in the same cycle).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "scaled_blit_source_address_gen_macros.svh"

module scaled_blit_source_address_gen
   import sbag_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   sbag_req_if.sink                   req_chan,
   sbag_rsp_if.source                 rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [STRIDE_W-1:0] row_stride_ff;
   logic [STEP_W-1:0]   column_step_ff;
   logic [STEP_W-1:0]   row_step_ff;
   logic [INDEX_W-1:0]  start_index_ff;
   logic [FRAC_W-1:0]   start_frac_ff;
   logic [COUNT_W-1:0]  columns_ff;
   logic [COUNT_W-1:0]  rows_ff;
   logic [MIRROR_W-1:0] mirror_mode_ff;

   csr_index_type       csr_sel;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_sel   = csr_index_type'(paddr[CSR_ADDR_W-1:3]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_stride_ff  <= ROW_STRIDE_RESET;
         column_step_ff <= COLUMN_STEP_RESET;
         row_step_ff    <= ROW_STEP_RESET;
         start_index_ff <= '0;
         start_frac_ff  <= '0;
         columns_ff     <= COUNT_RESET;
         rows_ff        <= COUNT_RESET;
         mirror_mode_ff <= '0;
      end else if (csr_write) begin
         case (csr_sel)
            REG_ROW_STRIDE:  row_stride_ff  <= pwdata[STRIDE_W-1:0];
            REG_COLUMN_STEP: column_step_ff <= pwdata[STEP_W-1:0];
            REG_ROW_STEP:    row_step_ff    <= pwdata[STEP_W-1:0];
            REG_START_INDEX: start_index_ff <= pwdata[INDEX_W-1:0];
            REG_START_FRAC:  start_frac_ff  <= pwdata[FRAC_W-1:0];
            REG_COLUMNS:     columns_ff     <= pwdata[COUNT_W-1:0];
            REG_ROWS:        rows_ff        <= pwdata[COUNT_W-1:0];
            REG_MIRROR_MODE: mirror_mode_ff <= pwdata[MIRROR_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back: zero-extend the selected register.
   always_comb begin
      case (csr_sel)
         REG_ROW_STRIDE:  prdata = CSR_DATA_W'(row_stride_ff);
         REG_COLUMN_STEP: prdata = CSR_DATA_W'(column_step_ff);
         REG_ROW_STEP:    prdata = CSR_DATA_W'(row_step_ff);
         REG_START_INDEX: prdata = CSR_DATA_W'(start_index_ff);
         REG_START_FRAC:  prdata = CSR_DATA_W'(start_frac_ff);
         REG_COLUMNS:     prdata = CSR_DATA_W'(columns_ff);
         REG_ROWS:        prdata = CSR_DATA_W'(rows_ff);
         REG_MIRROR_MODE: prdata = CSR_DATA_W'(mirror_mode_ff);
         default:         prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Walk state
   // ------------------------------------------------------------------
   logic [INDEX_W-1:0] index_acc_ff,  index_acc_in;
   logic [INDEX_W-1:0] row_start_ff,  row_start_in;
   logic [FRAC_W-1:0]  row_frac_ff,   row_frac_in;
   logic [CNT_W-1:0]   col_cnt_ff,    col_cnt_in;
   logic [CNT_W-1:0]   row_cnt_ff,    row_cnt_in;

   // Response register
   logic               rsp_valid_ff;
   logic [PIXEL_W-1:0] rsp_pixel_ff;
   logic               rsp_row_end_ff;
   logic               rsp_last_ff;

   logic               req_accept;

   // Current position, after an optional rewind
   logic [INDEX_W-1:0] cur_index;
   logic [INDEX_W-1:0] cur_row_start;
   logic [FRAC_W-1:0]  cur_frac;
   logic [CNT_W-1:0]   cur_col;
   logic [CNT_W-1:0]   cur_row;

   logic [CNT_W-1:0]   col_limit;
   logic [CNT_W-1:0]   row_limit;
   logic               row_end_c;
   logic               last_c;

   logic [STEP_W:0]    frac_sum;
   logic [WHOLE_W-1:0] whole_rows;
   logic [PROD_W-1:0]  row_product;
   logic [INDEX_W-1:0] row_delta;
   logic [INDEX_W-1:0] row_start_next;
   logic [INDEX_W-1:0] index_next;

   // Accept a request when the response slot is empty or draining now.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign col_limit = count_limit(columns_ff);
   assign row_limit = count_limit(rows_ff);

   always_comb begin
      if (req_chan.rewind) begin
         cur_index     = start_index_ff;
         cur_row_start = start_index_ff;
         cur_frac      = start_frac_ff;
         cur_col       = '0;
         cur_row       = '0;
      end else begin
         cur_index     = index_acc_ff;
         cur_row_start = row_start_ff;
         cur_frac      = row_frac_ff;
         cur_col       = col_cnt_ff;
         cur_row       = row_cnt_ff;
      end
   end

   // A counter at or past its limit counts as the end (limits may be lowered).
   assign row_end_c = cur_col >= col_limit;
   assign last_c    = row_end_c && (cur_row >= row_limit);

   // Row advance: whole source rows crossed times the stride, in 24.16.
   assign frac_sum    = {{(STEP_W + 1 - FRAC_W){1'b0}}, cur_frac} + {1'b0, row_step_ff};
   assign whole_rows  = frac_sum[STEP_W:FRAC_W];
   assign row_product = PROD_W'(whole_rows) * PROD_W'(row_stride_ff);
   assign row_delta   = {{(INDEX_W - PROD_W - FRAC_W){1'b0}}, row_product, {FRAC_W{1'b0}}};

   assign row_start_next = mirror_mode_ff[MIRROR_V_BIT] ? (cur_row_start - row_delta)
                                                        : (cur_row_start + row_delta);
   assign index_next     = mirror_mode_ff[MIRROR_H_BIT]
                           ? (cur_index - INDEX_W'(column_step_ff))
                           : (cur_index + INDEX_W'(column_step_ff));

   always_comb begin
      index_acc_in = cur_index;
      row_start_in = cur_row_start;
      row_frac_in  = cur_frac;
      col_cnt_in   = cur_col;
      row_cnt_in   = cur_row;
      if (last_c) begin
         // Wrap: go back to the region start.
         index_acc_in = start_index_ff;
         row_start_in = start_index_ff;
         row_frac_in  = start_frac_ff;
         col_cnt_in   = '0;
         row_cnt_in   = '0;
      end else if (row_end_c) begin
         row_frac_in  = frac_sum[FRAC_W-1:0];
         row_start_in = row_start_next;
         index_acc_in = row_start_next;
         col_cnt_in   = '0;
         row_cnt_in   = cur_row + CNT_W'(1);
      end else begin
         index_acc_in = index_next;
         col_cnt_in   = cur_col + CNT_W'(1);
      end
   end

   // Advance the walk and the response valid on accept; drop valid when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         index_acc_ff <= '0;
         row_start_ff <= '0;
         row_frac_ff  <= '0;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            index_acc_ff <= index_acc_in;
            row_start_ff <= row_start_in;
            row_frac_ff  <= row_frac_in;
            col_cnt_ff   <= col_cnt_in;
            row_cnt_ff   <= row_cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_pixel_ff   <= cur_index[INDEX_W-1:FRAC_W];
         rsp_row_end_ff <= row_end_c;
         rsp_last_ff    <= last_c;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_index = rsp_pixel_ff;
   assign rsp_chan.row_end     = rsp_row_end_ff;
   assign rsp_chan.last        = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `SBAG_ASSERT_SAME(a_last_ends_row, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_row_end_ff)
   `SBAG_ASSERT_NEXT(a_wrap_clears, clock, reset, req_accept && last_c,
                     (col_cnt_ff == '0) && (row_cnt_ff == '0))
   `SBAG_ASSERT_NEXT(a_row_return, clock, reset, req_accept && row_end_c && !last_c,
                     (index_acc_ff == row_start_ff) && (col_cnt_ff == '0))
   `SBAG_ASSERT_NEXT(a_col_advance, clock, reset, req_accept && !row_end_c,
                     (col_cnt_ff != '0) && $stable(row_cnt_ff) || $past(req_chan.rewind))

endmodule

`default_nettype wire
